// ----- rtl/ancc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ancc_pkg;

	localparam int USER_NAME_CAP   = 64;
	localparam int GROUP_NAME_CAP  = 64;
	localparam int MAX_PAYLOAD_LEN = 4096;

	// position saturates one above the limit, so it must hold MAX_PAYLOAD_LEN + 1
	localparam int POS_W   = $clog2(MAX_PAYLOAD_LEN + 2);
	localparam int UCNT_W  = $clog2(USER_NAME_CAP + 1);
	localparam int GCNT_W  = $clog2(GROUP_NAME_CAP + 1);
	localparam int TAG_LEN = 5;
	localparam int MIN_LEN = 6;

	localparam logic [7:0] LOOPBACK_NET = 8'd127;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NUL     = 8'h00;

	typedef enum logic [1:0] {
		PEER_NONE  = 2'd0,
		PEER_IPV4  = 2'd1,
		PEER_IPV6  = 2'd2,
		PEER_LOCAL = 2'd3
	} peer_kind_t;

	typedef enum logic [2:0] {
		PH_TAG   = 3'd0,
		PH_USKIP = 3'd1,
		PH_UTOK  = 3'd2,
		PH_GSKIP = 3'd3,
		PH_GTOK  = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_PEER      = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_BAD_GROUP = 3'd3,
		ST_BAD_USER  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [1:0]  peer_kind;
		logic [63:0] peer_addr_high;
		logic [63:0] peer_addr_low;
	} cred_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] user_offset;
		logic [5:0]  user_length;
		logic [11:0] group_offset;
		logic [5:0]  group_length;
	} verdict_beat_t;

	// "unix" followed by NUL
	function automatic logic [7:0] tag_byte(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h75;
			3'd1:    c = 8'h6e;
			3'd2:    c = 8'h69;
			3'd3:    c = 8'h78;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// [A-Za-z0-9_.@+-]
	function automatic logic name_byte_ok(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
			(b >= 8'h30 && b <= 8'h39) || b == 8'h5f || b == 8'h2d ||
			b == 8'h2e || b == 8'h40 || b == 8'h2b;
	endfunction

	function automatic logic peer_is_loopback(input logic [1:0] kind,
			input logic [63:0] hi, input logic [63:0] lo);
		logic r;
		unique case (kind)
			PEER_IPV4:  r = (lo[31:24] == LOOPBACK_NET);
			PEER_IPV6:  r = (hi == 64'd0) && (lo == 64'd1);
			PEER_LOCAL: r = 1'b1;
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/asserted_name_credential_check_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Credential checker: one payload byte per beat, one verdict per credential.
// Throughput: one byte per cycle; a byte sits in the input register, then the
// parse state and verdict update in one pass into the output register. A held,
// stalled verdict stalls the next byte until it is taken.
// The last byte is registered first, then its verdict in the output register.
// Reset: async active low; frame state returns to the tag phase, trust_remote = 0.

module asserted_name_credential_check_top (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cred_valid,
	output logic                    cred_stall,
	input  ancc_pkg::cred_beat_t    cred,
	output logic                    verdict_valid,
	input  wire                     verdict_stall,
	output ancc_pkg::verdict_beat_t verdict,
	input  wire                     cfg_we,
	input  wire                     cfg_wdata
);

	logic                    trust_remote_q;
	logic                    cred_vld_s1;
	ancc_pkg::cred_beat_t    cred_s1;
	logic                    verdict_vld_q;
	ancc_pkg::verdict_beat_t verdict_q;

	logic                    advance, cred_take, beat_fire, verdict_fire;
	ancc_pkg::verdict_beat_t verdict_d;

	// output register frees up when empty or when its beat is taken
	assign advance    = !verdict_vld_q || !verdict_stall;
	assign cred_stall = cred_vld_s1 && !advance;
	assign cred_take  = cred_valid && !cred_stall;
	assign beat_fire  = cred_vld_s1 && advance;

	ancc_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat_fire    (beat_fire),
		.beat         (cred_s1),
		.trust_remote (trust_remote_q),
		.verdict_fire (verdict_fire),
		.verdict      (verdict_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trust_remote_q <= 1'b0;
			cred_vld_s1    <= 1'b0;
			verdict_vld_q  <= 1'b0;
		end else begin
			if (cfg_we)
				trust_remote_q <= cfg_wdata;
			if (cred_take)
				cred_vld_s1 <= 1'b1;
			else if (advance)
				cred_vld_s1 <= 1'b0;
			if (verdict_fire)
				verdict_vld_q <= 1'b1;
			else if (!verdict_stall)
				verdict_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cred_take)
			cred_s1 <= cred;
		if (verdict_fire)
			verdict_q <= verdict_d;
	end

	assign verdict_valid = verdict_vld_q;
	assign verdict       = verdict_q;

endmodule

`default_nettype wire

// ----- rtl/ancc_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ancc_parse (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   beat_fire,
	input  ancc_pkg::cred_beat_t  beat,
	input  wire                   trust_remote,
	output logic                  verdict_fire,
	output ancc_pkg::verdict_beat_t verdict
);

	logic [ancc_pkg::POS_W-1:0]  pos_q, pos_e, pos_n;
	ancc_pkg::phase_t            phase_q, phase_e, phase_n;
	logic                        peer_q, peer_e, peer_n;
	logic                        tag_q, tag_e, tag_n;
	logic [ancc_pkg::POS_W-1:0]  ustart_q, ustart_e, ustart_n;
	logic [ancc_pkg::UCNT_W-1:0] ucnt_q, ucnt_e, ucnt_n;
	logic                        ubad_q, ubad_e, ubad_n;
	logic [ancc_pkg::POS_W-1:0]  gstart_q, gstart_e, gstart_n;
	logic [ancc_pkg::GCNT_W-1:0] gcnt_q, gcnt_e, gcnt_n;
	logic                        gbad_q, gbad_e, gbad_n;

	logic [7:0] b;
	logic       is_nul, is_space, b_ok;
	ancc_pkg::status_t st;

	assign b        = beat.data_byte;
	assign is_nul   = (b == ancc_pkg::CHAR_NUL);
	assign is_space = (b == ancc_pkg::CHAR_SPACE);
	assign b_ok     = ancc_pkg::name_byte_ok(b);

	// first_byte drops whatever frame was in progress
	assign pos_e    = beat.first_byte ? '0 : pos_q;
	assign phase_e  = beat.first_byte ? ancc_pkg::PH_TAG : phase_q;
	assign peer_e   = beat.first_byte ? 1'b0 : peer_q;
	assign tag_e    = beat.first_byte ? 1'b1 : tag_q;
	assign ustart_e = beat.first_byte ? '0 : ustart_q;
	assign ucnt_e   = beat.first_byte ? '0 : ucnt_q;
	assign ubad_e   = beat.first_byte ? 1'b0 : ubad_q;
	assign gstart_e = beat.first_byte ? '0 : gstart_q;
	assign gcnt_e   = beat.first_byte ? '0 : gcnt_q;
	assign gbad_e   = beat.first_byte ? 1'b0 : gbad_q;

	// phase transitions
	always_comb begin
		phase_n = phase_e;
		unique case (phase_e)
			ancc_pkg::PH_TAG: begin
				if (pos_e >= ancc_pkg::POS_W'(ancc_pkg::TAG_LEN - 1))
					phase_n = ancc_pkg::PH_USKIP;
			end
			ancc_pkg::PH_USKIP: begin
				if (is_nul)
					phase_n = ancc_pkg::PH_DONE;
				else if (!is_space)
					phase_n = ancc_pkg::PH_UTOK;
			end
			ancc_pkg::PH_UTOK: begin
				if (is_space)
					phase_n = ancc_pkg::PH_GSKIP;
				else if (is_nul)
					phase_n = ancc_pkg::PH_DONE;
			end
			ancc_pkg::PH_GSKIP: begin
				if (is_nul)
					phase_n = ancc_pkg::PH_DONE;
				else if (!is_space)
					phase_n = ancc_pkg::PH_GTOK;
			end
			ancc_pkg::PH_GTOK: begin
				if (is_space || is_nul)
					phase_n = ancc_pkg::PH_DONE;
			end
			default: phase_n = phase_e;
		endcase
	end

	// token bookkeeping
	always_comb begin
		peer_n   = peer_e;
		tag_n    = tag_e;
		ustart_n = ustart_e;
		ucnt_n   = ucnt_e;
		ubad_n   = ubad_e;
		gstart_n = gstart_e;
		gcnt_n   = gcnt_e;
		gbad_n   = gbad_e;

		if (pos_e == '0)
			peer_n = ancc_pkg::peer_is_loopback(beat.peer_kind, beat.peer_addr_high,
				beat.peer_addr_low);

		if (pos_e <= ancc_pkg::POS_W'(ancc_pkg::MAX_PAYLOAD_LEN))
			pos_n = pos_e + 1'b1;
		else
			pos_n = pos_e;

		unique case (phase_e)
			ancc_pkg::PH_TAG: begin
				if (pos_e < ancc_pkg::POS_W'(ancc_pkg::TAG_LEN) &&
						b != ancc_pkg::tag_byte(pos_e[2:0]))
					tag_n = 1'b0;
			end
			ancc_pkg::PH_USKIP: begin
				if (is_nul) begin
					ustart_n = pos_e;
				end else if (!is_space) begin
					ustart_n = pos_e;
					ucnt_n   = ancc_pkg::UCNT_W'(1);
					ubad_n   = !b_ok;
				end
			end
			ancc_pkg::PH_UTOK: begin
				if (!is_space && !is_nul) begin
					if (ucnt_e < ancc_pkg::UCNT_W'(ancc_pkg::USER_NAME_CAP))
						ucnt_n = ucnt_e + 1'b1;
					if (!b_ok)
						ubad_n = 1'b1;
				end
			end
			ancc_pkg::PH_GSKIP: begin
				if (!is_nul && !is_space) begin
					gstart_n = pos_e;
					gcnt_n   = ancc_pkg::GCNT_W'(1);
					gbad_n   = !b_ok;
				end
			end
			ancc_pkg::PH_GTOK: begin
				if (!is_space && !is_nul) begin
					if (gcnt_e < ancc_pkg::GCNT_W'(ancc_pkg::GROUP_NAME_CAP))
						gcnt_n = gcnt_e + 1'b1;
					if (!b_ok)
						gbad_n = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// verdict from the state after this byte; length = pos + 1
	always_comb begin
		priority if (!trust_remote && !peer_n)
			st = ancc_pkg::ST_PEER;
		else if (!tag_n || pos_e < ancc_pkg::POS_W'(ancc_pkg::MIN_LEN - 1) ||
				pos_e >= ancc_pkg::POS_W'(ancc_pkg::MAX_PAYLOAD_LEN))
			st = ancc_pkg::ST_MALFORMED;
		else if (gcnt_n != '0 &&
				(gcnt_n >= ancc_pkg::GCNT_W'(ancc_pkg::GROUP_NAME_CAP) || gbad_n))
			st = ancc_pkg::ST_BAD_GROUP;
		else if (ucnt_n == '0 || ucnt_n >= ancc_pkg::UCNT_W'(ancc_pkg::USER_NAME_CAP) ||
				ubad_n)
			st = ancc_pkg::ST_BAD_USER;
		else
			st = ancc_pkg::ST_OK;

		verdict.status = st;
		if (st == ancc_pkg::ST_OK) begin
			verdict.user_offset  = 12'(ustart_n);
			verdict.user_length  = 6'(ucnt_n);
			verdict.group_offset = (gcnt_n != '0) ? 12'(gstart_n) : 12'd0;
			verdict.group_length = 6'(gcnt_n);
		end else begin
			verdict.user_offset  = '0;
			verdict.user_length  = '0;
			verdict.group_offset = '0;
			verdict.group_length = '0;
		end
	end

	assign verdict_fire = beat_fire && beat.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= ancc_pkg::PH_TAG;
			peer_q   <= 1'b0;
			tag_q    <= 1'b1;
			ustart_q <= '0;
			ucnt_q   <= '0;
			ubad_q   <= 1'b0;
			gstart_q <= '0;
			gcnt_q   <= '0;
			gbad_q   <= 1'b0;
		end else if (beat_fire) begin
			if (beat.last_byte) begin
				pos_q    <= '0;
				phase_q  <= ancc_pkg::PH_TAG;
				peer_q   <= 1'b0;
				tag_q    <= 1'b1;
				ustart_q <= '0;
				ucnt_q   <= '0;
				ubad_q   <= 1'b0;
				gstart_q <= '0;
				gcnt_q   <= '0;
				gbad_q   <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				phase_q  <= phase_n;
				peer_q   <= peer_n;
				tag_q    <= tag_n;
				ustart_q <= ustart_n;
				ucnt_q   <= ucnt_n;
				ubad_q   <= ubad_n;
				gstart_q <= gstart_n;
				gcnt_q   <= gcnt_n;
				gbad_q   <= gbad_n;
			end
		end
	end

endmodule

`default_nettype wire
